[src/rrca_pkg.sv]
// Shared types and constants for the round-robin channel averager.
// No dependencies; imported by every module of the block.
`default_nettype none

package rrca_pkg;

    localparam int SAMPLES   = 10;
    localparam int NUM_SLOTS = 6;

    localparam int SAMPLE_W = 12;
    localparam int CH_W     = 3;
    localparam int CNT_W    = 4;
    localparam int ACC_W    = 16;
    localparam int TEMP_W   = 14;

    localparam logic [CH_W-1:0] TEMP_SLOT = 3'd4;
    localparam logic [CH_W-1:0] LAST_SLOT = CH_W'(NUM_SLOTS - 1);

    // sum / SAMPLES as (sum * AVG_MULT) >> AVG_SHIFT, exact for any 16-bit sum
    localparam int    AVG_SHIFT  = ACC_W + $clog2(SAMPLES);
    localparam longint AVG_MULT_L = ((64'd1 << AVG_SHIFT) + SAMPLES - 1) / SAMPLES;
    localparam int    AVG_MULT_W = ACC_W + 1;
    localparam logic [AVG_MULT_W-1:0] AVG_MULT = AVG_MULT_W'(AVG_MULT_L);

    // temperature: ((1762 - avg) * 1000 + 129250) / 517, truncated toward zero
    localparam int NUM_W   = 23;
    localparam int MAG_W   = NUM_W - 1;
    localparam logic signed [TEMP_W-1:0] TEMP_V25 = 14'sd1762;
    localparam logic signed [NUM_W-1:0] TEMP_SCALE  = 23'sd1000;
    localparam logic signed [NUM_W-1:0] TEMP_OFFSET = 23'sd129250;
    localparam int    TEMP_SLOPE  = 517;
    localparam int    TEMP_SHIFT  = MAG_W + $clog2(TEMP_SLOPE);
    localparam longint TEMP_MULT_L = ((64'd1 << TEMP_SHIFT) + TEMP_SLOPE - 1) / TEMP_SLOPE;
    localparam int    TEMP_MULT_W = 23;
    localparam logic [TEMP_MULT_W-1:0] TEMP_MULT = TEMP_MULT_W'(TEMP_MULT_L);
    localparam int    QUOT_W = 13;

    typedef struct packed {
        logic [CH_W-1:0] next_channel;
        logic            done;
        logic [CH_W-1:0] channel;
    } rrca_ctl_t;

endpackage

`default_nettype wire

[src/rrca_accum.sv]
// Channel sequencer and accumulator: keeps the slot, count and running sum.
// Depends on rrca_pkg.
`default_nettype none

module rrca_accum
    import rrca_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [SAMPLE_W-1:0] sample,
    output logic                     s_valid,
    input  wire logic                s_ready,
    output rrca_ctl_t                s_ctl,
    output logic [ACC_W-1:0]         s_sum
);

    logic [CH_W-1:0]  chan_reg, chan_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic             valid_reg;
    rrca_ctl_t        ctl_reg, ctl_next;
    logic [ACC_W-1:0] sum_reg;

    logic [CH_W-1:0]  ch_cur;
    logic [ACC_W-1:0] sum;
    logic [CNT_W:0]   cnt_inc;
    logic             done;
    logic             accept;

    assign in_ready = !valid_reg || s_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        ch_cur  = (chan_reg >= CH_W'(NUM_SLOTS)) ? '0 : chan_reg;
        sum     = acc_reg + ACC_W'(sample);
        cnt_inc = {1'b0, cnt_reg} + 1'b1;
        done    = (cnt_inc >= (CNT_W+1)'(SAMPLES));

        if (done)
        begin
            chan_next = (ch_cur == LAST_SLOT) ? '0 : ch_cur + 1'b1;
            cnt_next  = '0;
            acc_next  = '0;
        end
        else
        begin
            chan_next = ch_cur;
            cnt_next  = cnt_inc[CNT_W-1:0];
            acc_next  = sum;
        end

        ctl_next.next_channel = chan_next;
        ctl_next.done         = done;
        ctl_next.channel      = done ? ch_cur : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg  <= '0;
            cnt_reg   <= '0;
            acc_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                chan_reg <= chan_next;
                cnt_reg  <= cnt_next;
                acc_reg  <= acc_next;
            end
            if (in_ready)
                valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ctl_reg <= ctl_next;
            sum_reg <= sum;
        end
    end

    assign s_valid = valid_reg;
    assign s_ctl   = ctl_reg;
    assign s_sum   = sum_reg;

endmodule

`default_nettype wire

[src/rrca_divide.sv]
// Average stage: divides the completed sum by SAMPLES with a reciprocal multiply.
// Depends on rrca_pkg.
`default_nettype none

module rrca_divide
    import rrca_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire rrca_ctl_t        in_ctl,
    input  wire logic [ACC_W-1:0] in_sum,
    output logic                  s_valid,
    input  wire logic             s_ready,
    output rrca_ctl_t             s_ctl,
    output logic [SAMPLE_W-1:0]   s_avg
);

    logic                         valid_reg;
    rrca_ctl_t                    ctl_reg;
    logic [SAMPLE_W-1:0]          avg_reg, avg_next;
    logic [ACC_W+AVG_MULT_W-1:0]  prod;

    assign in_ready = !valid_reg || s_ready;

    always_comb
    begin
        prod     = (ACC_W+AVG_MULT_W)'(in_sum) * (ACC_W+AVG_MULT_W)'(AVG_MULT);
        // average reads zero unless this sample closed a slot
        avg_next = in_ctl.done ? prod[AVG_SHIFT +: SAMPLE_W] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            ctl_reg <= in_ctl;
            avg_reg <= avg_next;
        end
    end

    assign s_valid = valid_reg;
    assign s_ctl   = ctl_reg;
    assign s_avg   = avg_reg;

endmodule

`default_nettype wire

[src/rrca_temp.sv]
// Temperature conversion and result register: scales the slot-4 average to
// tenths of a degree and holds the last value. Depends on rrca_pkg.
`default_nettype none

module rrca_temp
    import rrca_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire rrca_ctl_t           in_ctl,
    input  wire logic [SAMPLE_W-1:0] in_avg,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [CH_W-1:0]          next_channel,
    output logic                     done_res,
    output logic [CH_W-1:0]          avg_channel,
    output logic [SAMPLE_W-1:0]      average,
    output logic signed [TEMP_W-1:0] cpu_temp
);

    // numerator stage
    logic                      num_valid_reg;
    rrca_ctl_t                 num_ctl_reg;
    logic [SAMPLE_W-1:0]       num_avg_reg;
    logic [MAG_W-1:0]          mag_reg, mag_next;
    logic                      neg_reg, neg_next;
    logic                      num_ready;
    logic signed [TEMP_W-1:0]  diff;
    logic signed [NUM_W-1:0]   num;

    // result stage
    logic                         out_valid_reg;
    rrca_ctl_t                    out_ctl_reg;
    logic [SAMPLE_W-1:0]          out_avg_reg;
    logic signed [TEMP_W-1:0]     temp_reg, temp_next;
    logic [MAG_W+TEMP_MULT_W-1:0] prod;
    logic [QUOT_W-1:0]            quot;
    logic                         out_load;

    assign num_ready = !out_valid_reg || out_ready;
    assign in_ready  = !num_valid_reg || num_ready;
    assign out_load  = num_ready && num_valid_reg;

    always_comb
    begin
        diff     = TEMP_V25 - $signed({2'b00, in_avg});
        num      = NUM_W'(diff) * TEMP_SCALE + TEMP_OFFSET;
        neg_next = num[NUM_W-1];
        mag_next = neg_next ? MAG_W'(-num) : num[MAG_W-1:0];
    end

    always_comb
    begin
        prod = (MAG_W+TEMP_MULT_W)'(mag_reg) * (MAG_W+TEMP_MULT_W)'(TEMP_MULT);
        quot = prod[TEMP_SHIFT +: QUOT_W];
        if (num_ctl_reg.done && num_ctl_reg.channel == TEMP_SLOT)
            temp_next = neg_reg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
        else
            temp_next = temp_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            temp_reg      <= '0;
        end
        else
        begin
            if (in_ready)
                num_valid_reg <= in_valid;
            if (num_ready)
                out_valid_reg <= num_valid_reg;
            // results leave in order, so the held value doubles as the output field
            if (out_load)
                temp_reg <= temp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            num_ctl_reg <= in_ctl;
            num_avg_reg <= in_avg;
            mag_reg     <= mag_next;
            neg_reg     <= neg_next;
        end
        if (out_load)
        begin
            out_ctl_reg <= num_ctl_reg;
            out_avg_reg <= num_avg_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign next_channel = out_ctl_reg.next_channel;
    assign done_res     = out_ctl_reg.done;
    assign avg_channel  = out_ctl_reg.channel;
    assign average      = out_avg_reg;
    assign cpu_temp     = temp_reg;

endmodule

`default_nettype wire

[src/round_robin_channel_averager.sv]
// Round-robin channel averager, top level.
// Throughput: one sample per cycle while out_ready is high; the four registered
// stages (accumulate, reciprocal divide, temperature numerator, temperature
// scale) each hold one item.
// Reset (rst_n, async low): slot 0, empty sum and count, temperature 0, no result.
// Depends on rrca_pkg, rrca_accum, rrca_divide, rrca_temp.
`default_nettype none

module round_robin_channel_averager
    import rrca_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [SAMPLE_W-1:0] sample,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [CH_W-1:0]          next_channel,
    output logic                     done_res,
    output logic [CH_W-1:0]          avg_channel,
    output logic [SAMPLE_W-1:0]      average,
    output logic signed [TEMP_W-1:0] cpu_temp
);

    logic                acc_valid;
    logic                acc_ready;
    rrca_ctl_t           acc_ctl;
    logic [ACC_W-1:0]    acc_sum;
    logic                div_valid;
    logic                div_ready;
    rrca_ctl_t           div_ctl;
    logic [SAMPLE_W-1:0] div_avg;

    rrca_accum u_accum (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sample   (sample),
        .s_valid  (acc_valid),
        .s_ready  (acc_ready),
        .s_ctl    (acc_ctl),
        .s_sum    (acc_sum)
    );

    rrca_divide u_divide (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (acc_valid),
        .in_ready (acc_ready),
        .in_ctl   (acc_ctl),
        .in_sum   (acc_sum),
        .s_valid  (div_valid),
        .s_ready  (div_ready),
        .s_ctl    (div_ctl),
        .s_avg    (div_avg)
    );

    rrca_temp u_temp (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (div_valid),
        .in_ready     (div_ready),
        .in_ctl       (div_ctl),
        .in_avg       (div_avg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .next_channel (next_channel),
        .done_res     (done_res),
        .avg_channel  (avg_channel),
        .average      (average),
        .cpu_temp     (cpu_temp)
    );

endmodule

`default_nettype wire
